FILE: design/rilbp_pkg.sv
// ----------------------------------------------------------------------------
// rilbp_pkg: shared definitions for the rotation-invariant LBP block
// Sizes, configuration register indexes, the line-store write bundle and the
// helper functions used by the datapath.
// ----------------------------------------------------------------------------
package rilbp_pkg;

  // Frame and pixel geometry
  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 1024;
  localparam int MIN_SIZE       = 3;
  localparam int PIXEL_BITS     = 8;
  localparam int CODE_BITS      = 8;
  localparam int SIZE_BITS      = 11;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
  localparam int WIN_TAPS       = 9;
  localparam int CFG_INDEX_BITS = 2;
  localparam int IN_DATA_BITS   = ((PIXEL_BITS + 7) / 8) * 8;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [CODE_BITS-1:0]  code_t;
  typedef logic [SIZE_BITS-1:0]  size_t;
  typedef logic [COL_BITS-1:0]   col_t;
  typedef logic [ROW_BITS-1:0]   row_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 0,
    REG_FRAME_HEIGHT = 1
  } cfg_reg_t;

  // Write request into both line stores at one column
  typedef struct packed {
    logic   en;
    col_t   addr;
    pixel_t upper;
    pixel_t middle;
  } lb_wr_t;

  // Saturate a written frame size into MIN_SIZE..hi.
  function automatic size_t clamp_size(input size_t v, input size_t hi);
    size_t r;
    if (v < size_t'(MIN_SIZE)) begin
      r = size_t'(MIN_SIZE);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Smallest value among the eight circular rotations of a byte.
  function automatic code_t min_rotation(input code_t code);
    code_t rot;
    code_t best;
    rot  = code;
    best = code;
    for (int k = 1; k < CODE_BITS; k++) begin
      rot = {rot[CODE_BITS-2:0], rot[CODE_BITS-1]};
      if (rot < best) begin
        best = rot;
      end
    end
    return best;
  endfunction

endpackage

FILE: design/rilbp_line_buf.sv
// ----------------------------------------------------------------------------
// rilbp_line_buf: two line stores for the 3x3 window
// Holds the previous two image rows. One registered read of both stores per
// accepted pixel, one write of both stores per pixel leaving the first stage.
// ----------------------------------------------------------------------------
module rilbp_line_buf (
  input  logic                    clk,
  input  logic                    rd_en,
  input  rilbp_pkg::col_t         rd_addr,
  output rilbp_pkg::pixel_t       rd_upper,
  output rilbp_pkg::pixel_t       rd_middle,
  input  rilbp_pkg::lb_wr_t       wr
);
  import rilbp_pkg::*;

  pixel_t upper_mem  [MAX_WIDTH];
  pixel_t middle_mem [MAX_WIDTH];

  // Write port: the old middle row moves up, the new pixel enters the middle row.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      upper_mem[wr.addr]  <= wr.upper;
      middle_mem[wr.addr] <= wr.middle;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper  <= upper_mem[rd_addr];
      rd_middle <= middle_mem[rd_addr];
    end
  end

endmodule

FILE: design/rilbp_code.sv
// ----------------------------------------------------------------------------
// rilbp_code: neighbour threshold and rotation-invariant code
// Compares the eight neighbours with the centre, takes the minimum over the
// eight rotations of the resulting byte and registers it.
// ----------------------------------------------------------------------------
module rilbp_code (
  input  logic              clk,
  input  logic              en,
  input  rilbp_pkg::pixel_t window [rilbp_pkg::WIN_TAPS],
  output rilbp_pkg::code_t  code
);
  import rilbp_pkg::*;

  pixel_t centre;
  code_t  bits;

  // Window index is row * 3 + column; bits run clockwise from the top-left,
  // first neighbour in the MSB.
  always_comb begin
    centre = window[4];
    bits   = {window[0] >= centre, window[1] >= centre, window[2] >= centre,
              window[5] >= centre, window[8] >= centre, window[7] >= centre,
              window[6] >= centre, window[3] >= centre};
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (en) begin
      code <= min_rotation(bits);
    end
  end

endmodule

FILE: design/rotation_invariant_lbp_3x3_top.sv
// ----------------------------------------------------------------------------
// rotation_invariant_lbp_3x3_top: rotation-invariant 8-neighbour LBP filter
// Streams a raster frame of pixels in and one pattern code per interior
// pixel out.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the output word is free or being
// taken. The code a pixel completes passes through registers in order: the
// edge that accepts the pixel registers the read of the two line stores,
// the window shift follows, and then the threshold and rotation minimum are
// loaded into the output register, each step as the pipe advances. The output
// register decouples the sides, so s_tready stays high while the output word
// is free or being taken. Codes are produced only for interior pixels, so the
// first two rows and the first two columns of each row give no word. Writing
// either frame size restarts the frame at row 0, column 0; sizes saturate to
// 3..1024. The line stores need no clearing after reset, as the first two
// rows of every frame fill each column before it is read.
// ----------------------------------------------------------------------------
module rotation_invariant_lbp_3x3_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // Pixel input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [rilbp_pkg::IN_DATA_BITS-1:0]   s_tdata,   // [7:0] pixel
  // Code output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [rilbp_pkg::CODE_BITS-1:0]      m_tdata,   // [7:0] pattern_code
  output logic                                 m_tlast,   // row_end
  output logic                                 m_tuser,   // [0] frame_end
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rilbp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rilbp_pkg::SIZE_BITS-1:0]      cfg_data
);
  import rilbp_pkg::*;

  // Configuration and position state
  size_t  frame_width;
  size_t  frame_height;
  col_t   col;
  row_t   row;

  // Stage 1: pixel with its line-store read
  logic   s1_valid;
  pixel_t s1_pixel;
  col_t   s1_col;
  logic   s1_emit;
  logic   s1_row_end;
  logic   s1_frame_end;
  pixel_t rd_upper;
  pixel_t rd_middle;

  // Stage 2: window
  pixel_t window [WIN_TAPS];
  logic   s2_valid;
  logic   s2_row_end;
  logic   s2_frame_end;

  logic   adv;
  logic   accept;
  logic   cfg_write;
  logic   last_col;
  logic   last_row;
  size_t  width_m1;
  size_t  height_m1;
  pixel_t pixel_in;
  lb_wr_t lb_wr;
  code_t  code;

  // The whole pipe moves whenever the output word is free or taken.
  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign pixel_in  = s_tdata[PIXEL_BITS-1:0];

  // Position decode for the incoming pixel.
  always_comb begin
    width_m1  = frame_width - size_t'(1);
    height_m1 = frame_height - size_t'(1);
    last_col  = (col == width_m1[COL_BITS-1:0]);
    last_row  = (row == height_m1[ROW_BITS-1:0]);
  end

  // Frame size registers and raster counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= size_t'(MAX_WIDTH);
      frame_height <= size_t'(MAX_HEIGHT);
      col          <= '0;
      row          <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH: begin
          frame_width <= clamp_size(cfg_data, size_t'(MAX_WIDTH));
          col         <= '0;
          row         <= '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= clamp_size(cfg_data, size_t'(MAX_HEIGHT));
          col          <= '0;
          row          <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + row_t'(1);
      end else begin
        col <= col + col_t'(1);
      end
    end
  end

  // Line stores: read on accept, write as the pixel leaves stage 1.
  always_comb begin
    lb_wr.en     = s1_valid && adv;
    lb_wr.addr   = s1_col;
    lb_wr.upper  = rd_middle;
    lb_wr.middle = s1_pixel;
  end

  rilbp_line_buf u_line_buf (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (col),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle),
    .wr        (lb_wr)
  );

  // Stage 1 control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel     <= pixel_in;
      s1_col       <= col;
      s1_emit      <= (row >= row_t'(2)) && (col >= col_t'(2));
      s1_row_end   <= last_col;
      s1_frame_end <= last_col && last_row;
    end
  end

  // Window shift: left by one column, new right column from the stores.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_TAPS; i++) begin
        window[i] <= '0;
      end
    end else if (s1_valid && adv) begin
      window[0] <= window[1];
      window[1] <= window[2];
      window[2] <= rd_upper;
      window[3] <= window[4];
      window[4] <= window[5];
      window[5] <= rd_middle;
      window[6] <= window[7];
      window[7] <= window[8];
      window[8] <= s1_pixel;
    end
  end

  // Stage 2 control and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_row_end   <= s1_row_end;
      s2_frame_end <= s1_frame_end;
    end
  end

  // Code computation into the output register.
  rilbp_code u_code (
    .clk    (clk),
    .en     (adv),
    .window (window),
    .code   (code)
  );

  // Output word control and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tlast <= s2_row_end;
      m_tuser <= s2_frame_end;
    end
  end

  assign m_tdata = code;

endmodule

FILE: design/rilbp_checker.sv
// ----------------------------------------------------------------------------
// rilbp_checker: port-level checks for the LBP filter
// Watches the top-level ports over time and flags handshake and flag errors.
// ----------------------------------------------------------------------------
module rilbp_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tready,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [rilbp_pkg::CODE_BITS-1:0]      m_tdata,
  input logic                                 m_tlast,
  input logic                                 m_tuser,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready
);
  import rilbp_pkg::*;

  // A stalled output word keeps its value and flags.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("output word changed while stalled");

  // The frame end always falls on the end of a row.
  a_frame_in_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame end without row end");

  // With the output word free the input is never held back.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

  // Configuration writes are always taken.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind rotation_invariant_lbp_3x3_top rilbp_checker u_checker (.*);

FILE: sim/lbp_code_checker.sv
// ----------------------------------------------------------------------------
// lbp_code_checker: pattern code predictor and comparator
// Watches the pixel, code and register channels of the LBP filter. It keeps
// its own line stores, 3x3 window and frame position, queues the code each
// interior pixel must produce and compares every accepted code word with it.
// ----------------------------------------------------------------------------
module lbp_code_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  input  logic                                 s_tready,
  input  logic [rilbp_pkg::IN_DATA_BITS-1:0]   s_tdata,
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic [rilbp_pkg::CODE_BITS-1:0]      m_tdata,
  input  logic                                 m_tlast,
  input  logic                                 m_tuser,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [rilbp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rilbp_pkg::SIZE_BITS-1:0]      cfg_data,
  output int                                   pending_words,
  output int                                   failures
);
  import rilbp_pkg::*;

  // Window taps of the eight neighbors, clockwise from the top-left.
  localparam int RING_TAP [8] = '{0, 1, 2, 5, 8, 7, 6, 3};

  typedef struct packed {
    code_t pattern;
    logic  row_end;
    logic  frame_end;
  } code_word_t;

  pixel_t      upper_row [MAX_WIDTH];
  pixel_t      middle_row [MAX_WIDTH];
  pixel_t      tap [WIN_TAPS];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned frame_cols;
  int unsigned frame_rows;
  code_word_t  due_codes [$];

  function automatic int unsigned saturate_size(input int unsigned value,
                                                input int unsigned ceiling);
    if (value < MIN_SIZE) begin
      return MIN_SIZE;
    end
    if (value > ceiling) begin
      return ceiling;
    end
    return value;
  endfunction

  always @(posedge clk) begin : observe
    code_word_t  got;
    code_word_t  want;
    code_word_t  fresh;
    code_t       ring;
    code_t       turned;
    int unsigned c;
    int unsigned r;
    int          bad;
    bad = 0;
    if (rst) begin
      for (int i = 0; i < WIN_TAPS; i++) begin
        tap[i] = '0;
      end
      col_pos    = 0;
      row_pos    = 0;
      frame_cols = MAX_WIDTH;
      frame_rows = MAX_HEIGHT;
      due_codes.delete();
      failures <= 0;
    end else begin
      // A size write restarts the frame; other indexes change nothing.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          frame_cols = saturate_size(int'(cfg_data), MAX_WIDTH);
          col_pos    = 0;
          row_pos    = 0;
        end else if (cfg_index == REG_FRAME_HEIGHT) begin
          frame_rows = saturate_size(int'(cfg_data), MAX_HEIGHT);
          col_pos    = 0;
          row_pos    = 0;
        end
      end

      // Compare an accepted code word with the oldest prediction.
      if (m_tvalid && m_tready) begin
        got.pattern   = m_tdata;
        got.row_end   = m_tlast;
        got.frame_end = m_tuser;
        if (due_codes.size() == 0) begin
          $error("unexpected code word: pattern_code %0d, row_end %0b, frame_end %0b",
                 got.pattern, got.row_end, got.frame_end);
          bad++;
        end else begin
          want = due_codes.pop_front();
          if (got.pattern !== want.pattern) begin
            $error("pattern_code: expected %0d, actual %0d", want.pattern, got.pattern);
            bad++;
          end
          if (got.row_end !== want.row_end) begin
            $error("row_end: expected %0b, actual %0b", want.row_end, got.row_end);
            bad++;
          end
          if (got.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end, got.frame_end);
            bad++;
          end
        end
      end

      // Shift the window by one pixel and predict the code it completes.
      if (s_tvalid && s_tready) begin
        c = col_pos;
        r = row_pos;
        tap[0] = tap[1];
        tap[1] = tap[2];
        tap[2] = upper_row[c];
        tap[3] = tap[4];
        tap[4] = tap[5];
        tap[5] = middle_row[c];
        tap[6] = tap[7];
        tap[7] = tap[8];
        tap[8] = s_tdata[PIXEL_BITS-1:0];
        upper_row[c]  = middle_row[c];
        middle_row[c] = s_tdata[PIXEL_BITS-1:0];
        if (r >= 2 && c >= 2) begin
          ring = '0;
          for (int k = 0; k < 8; k++) begin
            ring = {ring[CODE_BITS-2:0], tap[RING_TAP[k]] >= tap[4]};
          end
          // Smallest of the eight left rotations of the neighbor byte.
          fresh.pattern = ring;
          for (int k = 1; k < 8; k++) begin
            turned = code_t'({ring, ring} >> (8 - k));
            if (turned < fresh.pattern) begin
              fresh.pattern = turned;
            end
          end
          fresh.row_end   = (c + 1 == frame_cols);
          fresh.frame_end = fresh.row_end && (r + 1 == frame_rows);
          due_codes.push_back(fresh);
        end
        c++;
        if (c >= frame_cols) begin
          c = 0;
          r++;
          if (r >= frame_rows) begin
            r = 0;
          end
        end
        col_pos = c;
        row_pos = r;
      end
      failures <= failures + bad;
    end
    pending_words <= due_codes.size();
  end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the rotation-invariant LBP filter
// Streams directed 3x3 frames, partial frames at the widest and tallest
// sizes and many small random frames, with random gaps on both sides, a long
// receiver hold-off, mid-frame restarts and writes to unused register
// indexes. A separate checker predicts and compares every code word.
// ----------------------------------------------------------------------------
module testbench;
  import rilbp_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LOW  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HIGH = 2'd3;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int RANDOM_PIXELS    = 600;
  localparam int WIDE_PIXELS      = MAX_WIDTH + 8;
  localparam int TALL_ROWS        = 50;

  // Three 3x3 frames: alternating neighbors, a dark center, a lone bright corner.
  localparam pixel_t TRIAL_PIXELS [27] = '{
    8'd0,   8'd255, 8'd0,   8'd255, 8'd128, 8'd255, 8'd0,   8'd255, 8'd0,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0
  };

  typedef enum int {MIX_FULL, MIX_NEAR, MIX_EXTREME} pixel_mix_t;

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [IN_DATA_BITS-1:0]   s_tdata;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [CODE_BITS-1:0]      m_tdata;
  logic                      m_tlast;
  logic                      m_tuser;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [SIZE_BITS-1:0]      cfg_data;

  int         pending_words;
  int         failures;
  int         idle_cycles;
  int         tx_gap_max;
  bit         rx_stall_on;
  bit         hold_wanted;
  pixel_mix_t pixel_mix;
  int         random_pixels;

  rotation_invariant_lbp_3x3_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lbp_code_checker code_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending_words (pending_words),
    .failures      (failures)
  );

  // Clock with a period of 12.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: ends the run when no word moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Code receiver: a random stall before each word, or one long hold-off.
  initial begin
    int stall;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_wanted) begin
        stall       = LONG_HOLD_CYCLES;
        hold_wanted = 1'b0;
      end else begin
        stall = rx_stall_on ? $urandom_range(0, 8) : 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  function automatic pixel_t draw_pixel();
    case (pixel_mix)
      MIX_FULL: begin
        return pixel_t'($urandom_range(0, 255));
      end
      MIX_NEAR: begin
        return pixel_t'($urandom_range(100, 103));
      end
      default: begin
        return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
    endcase
  endfunction

  // Offer one pixel after a random gap and wait until it is taken.
  task automatic push_pixel(input pixel_t value);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic run_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      push_pixel(draw_pixel());
    end
  endtask

  // Stop sending and wait until every predicted code has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no toggle.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [SIZE_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic setup_frame(input logic [SIZE_BITS-1:0] cols_value,
                             input logic [SIZE_BITS-1:0] rows_value,
                             input bit spare);
    if ($urandom_range(0, 1)) begin
      write_reg(REG_FRAME_WIDTH, cols_value);
      write_reg(REG_FRAME_HEIGHT, rows_value);
    end else begin
      write_reg(REG_FRAME_HEIGHT, rows_value);
      write_reg(REG_FRAME_WIDTH, cols_value);
    end
    if (spare) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_LOW : REG_SPARE_HIGH,
                SIZE_BITS'($urandom_range(0, 2047)));
    end
    cfg_valid <= 1'b0;
  endtask

  // Main stimulus and verdict.
  initial begin
    int cols;
    int rows;
    int frames;
    int part;
    int cut;
    bit first_phase;
    s_tvalid      <= 1'b0;
    s_tdata       <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    rst           <= 1'b1;
    tx_gap_max    = 0;
    rx_stall_on   = 1'b0;
    hold_wanted   = 1'b0;
    pixel_mix     = MIX_FULL;
    random_pixels = 0;
    first_phase   = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes: part of row 0 of a 1024-wide frame gives no code.
    run_pixels(40);
    drain();

    // Directed 3x3 frames; both sizes are written below the minimum.
    tx_gap_max  = 8;
    rx_stall_on = 1'b1;
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, SIZE_BITS'(2));
    cfg_valid <= 1'b0;
    for (int i = 0; i < 27; i++) begin
      push_pixel(TRIAL_PIXELS[i]);
    end
    drain();

    // Widest rows: width saturates from all ones, height from zero. The
    // frame stops just past the first row wrap, so no code is due.
    pixel_mix = MIX_NEAR;
    setup_frame('1, '0, 1'b1);
    run_pixels(WIDE_PIXELS);
    drain();

    // Tallest frame at the narrowest width, stopped after its first rows.
    pixel_mix   = MIX_FULL;
    tx_gap_max  = 0;
    rx_stall_on = 1'b0;
    setup_frame(SIZE_BITS'(MIN_SIZE), SIZE_BITS'(MAX_HEIGHT), 1'b0);
    run_pixels(MIN_SIZE * TALL_ROWS);
    drain();

    // Random small frames with random gaps, restarts and unused writes.
    while (random_pixels < RANDOM_PIXELS) begin
      tx_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 8;
      rx_stall_on = ($urandom_range(0, 3) != 0);
      pixel_mix   = pixel_mix_t'($urandom_range(0, 2));
      if (first_phase) begin
        // Sender keeps offering while the receiver holds off.
        tx_gap_max  = 0;
        hold_wanted = 1'b1;
        first_phase = 1'b0;
      end
      cols = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
      rows = $urandom_range(3, 8);
      if ($urandom_range(0, 9) == 0) begin
        cols = MIN_SIZE;
        setup_frame(SIZE_BITS'($urandom_range(0, 2)), SIZE_BITS'(rows),
                    $urandom_range(0, 3) == 0);
      end else begin
        setup_frame(SIZE_BITS'(cols), SIZE_BITS'(rows), $urandom_range(0, 3) == 0);
      end
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        cut  = $urandom_range(0, 5);
        part = $urandom_range(1, cols * rows - 1);
        if (cut == 0) begin
          // Stop mid-frame; the next size write restarts the frame.
          run_pixels(part);
          random_pixels += part;
          break;
        end else if (cut == 1) begin
          // A write to an unused index mid-frame must leave the position alone.
          run_pixels(part);
          drain();
          write_reg($urandom_range(0, 1) ? REG_SPARE_LOW : REG_SPARE_HIGH,
                    SIZE_BITS'($urandom_range(0, 2047)));
          cfg_valid <= 1'b0;
          run_pixels(cols * rows - part);
        end else begin
          run_pixels(cols * rows);
        end
        random_pixels += cols * rows;
      end
      drain();
    end

    @(negedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
